// File: hdl/ptts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptts_pkg;

  localparam int unsigned TASK_IDX_W = 4;

  localparam logic [1:0] REQ_TICK     = 2'd0;
  localparam logic [1:0] REQ_ADD      = 2'd1;
  localparam logic [1:0] REQ_DISPATCH = 2'd2;

  localparam logic [1:0] KIND_ADD_OK   = 2'd0;
  localparam logic [1:0] KIND_ADD_FULL = 2'd1;
  localparam logic [1:0] KIND_DUE      = 2'd2;
  localparam logic [1:0] KIND_NONE     = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] start_delay;
    logic [31:0] reload_period;
  } ptts_in_t;

  typedef struct packed {
    logic [1:0]            result_kind;
    logic [TASK_IDX_W-1:0] task_index;
    logic                  last;
  } ptts_out_t;

  typedef struct packed {
    logic [31:0] countdown;
    logic [31:0] period;
    logic [7:0]  pending;
  } ptts_entry_t;

endpackage

`default_nettype wire

// File: hdl/ptts_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ptts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hdl/periodic_task_tick_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none

// Time-triggered task table with up to MAX_TASKS slots held in one on-chip RAM
// (countdown, reload period and pending-run count per slot). An add request returns one
// transfer with the new slot index or a table-full result. A tick or a dispatch walks the
// filled slots through the RAM, reading one slot and writing the previous one back each
// cycle unless stalled. A dispatch stalls when it finds a due slot while one is held
// and the output register is still occupied, and waits for it to free before its last
// transfer. The single read port of the slot RAM sets this one-slot-per-cycle pace.
// A tick returns nothing. A dispatch returns one transfer per due slot in slot order, the
// final one marked with last, or a single none-due transfer. Request code 3 is dropped.
module periodic_task_tick_scheduler
  import ptts_pkg::*;
#(
  parameter int unsigned MAX_TASKS = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire ptts_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output ptts_out_t      out_data_o
);

  localparam int unsigned AddrW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_TASKS + 1);
  localparam int unsigned EntW  = $bits(ptts_entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EMIT
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] count_q;
  logic [AddrW-1:0] slot_q;
  logic            op_dispatch_q;
  logic            held_valid_q;
  logic [AddrW-1:0] held_idx_q;
  ptts_out_t       res_q;
  logic            out_valid_q;
  ptts_out_t       out_data_q;

  logic            in_xfer;
  logic            out_free;
  logic            full;
  logic            last_slot;
  logic            due;
  logic            advance;
  logic            ram_we;
  logic [AddrW-1:0] ram_waddr;
  ptts_entry_t     ram_wdata;
  logic            ram_re;
  logic [AddrW-1:0] ram_raddr;
  ptts_entry_t     ram_rdata;
  ptts_entry_t     upd;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign full        = (count_q == CntW'(MAX_TASKS));
  assign last_slot   = (CntW'(slot_q) == count_q - CntW'(1));
  assign due         = (ram_rdata.pending != 8'd0);
  assign advance     = !(op_dispatch_q && due && held_valid_q && !out_free);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    upd = ram_rdata;
    if (op_dispatch_q) begin
      if (due) begin
        upd.pending = ram_rdata.pending - 8'd1;
      end
    end else if (ram_rdata.countdown != 32'd0) begin
      upd.countdown = ram_rdata.countdown - 32'd1;
    end else begin
      upd.countdown = ram_rdata.period;
      if (ram_rdata.pending != 8'hFF) begin
        upd.pending = ram_rdata.pending + 8'd1;
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_q;
    ram_wdata = upd;
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (state_q == ST_IDLE) begin
      ram_waddr = count_q[AddrW-1:0];
      ram_wdata = '{countdown: in_data_i.start_delay,
                    period:    in_data_i.reload_period,
                    pending:   8'd0};
      ram_we    = in_xfer && (in_data_i.req_type == REQ_ADD) && !full;
      ram_re    = in_xfer && (count_q != '0) &&
                  ((in_data_i.req_type == REQ_TICK) || (in_data_i.req_type == REQ_DISPATCH));
    end else if (state_q == ST_WALK) begin
      ram_we    = advance;
      ram_re    = advance && !last_slot;
      ram_raddr = slot_q + AddrW'(1);
    end
  end

  ptts_ram #(
    .Width (EntW),
    .Depth (MAX_TASKS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_q       <= '0;
      slot_q        <= '0;
      op_dispatch_q <= 1'b0;
      held_valid_q  <= 1'b0;
      held_idx_q    <= '0;
      res_q         <= '0;
      out_valid_q   <= 1'b0;
      out_data_q    <= '0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            slot_q        <= '0;
            held_valid_q  <= 1'b0;
            op_dispatch_q <= (in_data_i.req_type == REQ_DISPATCH);
            priority if (in_data_i.req_type == REQ_ADD) begin
              state_q <= ST_EMIT;
              if (full) begin
                res_q <= '{result_kind: KIND_ADD_FULL, task_index: '0, last: 1'b1};
              end else begin
                res_q   <= '{result_kind: KIND_ADD_OK,
                             task_index:  TASK_IDX_W'(count_q), last: 1'b1};
                count_q <= count_q + CntW'(1);
              end
            end else if (in_data_i.req_type == REQ_TICK) begin
              if (count_q != '0) begin
                state_q <= ST_WALK;
              end
            end else if (in_data_i.req_type == REQ_DISPATCH) begin
              if (count_q != '0) begin
                state_q <= ST_WALK;
              end else begin
                res_q   <= '{result_kind: KIND_NONE, task_index: '0, last: 1'b1};
                state_q <= ST_EMIT;
              end
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_WALK: begin
          if (advance) begin
            if (op_dispatch_q && due) begin
              held_valid_q <= 1'b1;
              held_idx_q   <= slot_q;
              if (held_valid_q) begin
                out_valid_q <= 1'b1;
                out_data_q  <= '{result_kind: KIND_DUE,
                                 task_index:  TASK_IDX_W'(held_idx_q), last: 1'b0};
              end
            end
            if (last_slot) begin
              if (op_dispatch_q) begin
                state_q <= ST_EMIT;
                if (due) begin
                  res_q <= '{result_kind: KIND_DUE,
                             task_index:  TASK_IDX_W'(slot_q), last: 1'b1};
                end else if (held_valid_q) begin
                  res_q <= '{result_kind: KIND_DUE,
                             task_index:  TASK_IDX_W'(held_idx_q), last: 1'b1};
                end else begin
                  res_q <= '{result_kind: KIND_NONE, task_index: '0, last: 1'b1};
                end
              end else begin
                state_q <= ST_IDLE;
              end
            end else begin
              slot_q <= slot_q + AddrW'(1);
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_data_q   <= res_q;
            held_valid_q <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_TASKS))
    else $error("task count exceeds the table size");

  a_idle_no_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !held_valid_q)
    else $error("due slot still held while idle");

  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (in_data_i.req_type == REQ_ADD) && !full)
      |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("accepted add did not fill a slot");

  a_walk_stall_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_WALK) && !advance) |-> (out_valid_q && !out_ready_i))
    else $error("walk stalled with a free output register");

endmodule

`default_nettype wire
